// ----- hw/rtl/itrb_pkg.sv -----
// Package for the in-order task retire buffer: sizes, codes and item types.
// Used by hw/rtl/in_order_task_retire_buffer.sv; depends on nothing else.
`default_nettype none

package itrb_pkg;

  localparam int MAX_SLOTS   = 32;
  localparam int HANDLE_BITS = 16;
  localparam int RESULT_CAP  = 32;

  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int REM_W  = $clog2(RESULT_CAP);

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [APB_AW-1:0] REG_TASK_COUNT_ADDR = 3'd0;
  localparam logic [CNT_W-1:0]  TASK_COUNT_RESET    = CNT_W'(MAX_SLOTS);

  localparam logic [1:0] MODE_RESTART = 2'd0;
  localparam logic [1:0] MODE_REQUEST = 2'd1;
  localparam logic [1:0] MODE_SUBMIT  = 2'd2;

  typedef enum logic [1:0] {
    ST_WAIT = 2'd0,
    ST_PEND = 2'd1,
    ST_DONE = 2'd2
  } slot_st_e;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_SCAN   = 6'b000100,
    S_FIRST  = 6'b001000,
    S_READ   = 6'b010000,
    S_EMIT   = 6'b100000
  } state_e;

  typedef struct packed {
    logic [1:0]             mode;
    logic [SLOT_W-1:0]      first_slot;
    logic [CNT_W-1:0]       slot_run;
    logic [HANDLE_BITS-1:0] work_handle;
  } in_item_t;

  typedef struct packed {
    logic                   granted;
    logic [SLOT_W-1:0]      granted_slot;
    logic                   handle_valid;
    logic [HANDLE_BITS-1:0] released_handle;
    logic                   last;
    logic [CNT_W-1:0]       finished_slots;
    logic                   all_finished;
  } out_item_t;

endpackage

`default_nettype wire

// ----- hw/rtl/in_order_task_retire_buffer.sv -----
// Top level of the in-order task retire buffer: slot table, retire walker and APB register.
// Depends on itrb_pkg for sizes, codes and the item structs.
`default_nettype none

// The block hands out task slots in order and releases finished work handles strictly in
// slot order. One item comes in on the in_* valid/ready channel; one or more result items
// leave on the out_* channel, the final one of each input marked by last. Every result
// carries the finished slot count and the all-finished flag after the whole input.
// The APB port holds one register, task_count, at byte address 0; write it only while idle.
// Rate: the block takes one item at a time and in_ready_o is high only when idle.
// A restart, a request, a held (pending) submit or an ignored submit has its result loaded
// into the output register from the decode state, and the block then returns to idle.
// A releasing submit first scans the pending runs to find the final count, then offers the
// handle of the input item, and then for each stored handle reads the handle memory in
// S_READ and loads the output register in S_EMIT.
// After reset all slots read as not finished with zero length, both counters are zero and
// task_count is 32; the handle memory is not cleared and only written entries are read.
// A stalled receiver simply holds the output register: the sequencer waits in its decode,
// first or emit state until the waiting result is taken, so nothing is lost or repeated.
module in_order_task_retire_buffer
  import itrb_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // input channel
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire in_item_t          in_data_i,
  // output channel
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output out_item_t              out_data_o,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  // Control and bookkeeping registers.
  state_e           state_q, state_d;
  logic [CNT_W-1:0] task_count_q;
  logic [CNT_W-1:0] disp_q, disp_d;
  logic [CNT_W-1:0] rel_q, rel_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] end_q, end_d;
  logic [CNT_W-1:0] fin_q, fin_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic             out_valid_q, out_valid_d;

  // Payload registers.
  in_item_t               in_q;
  out_item_t              out_q, out_d;
  logic                   out_load;
  logic [HANDLE_BITS-1:0] hrd_q;

  // Slot table: status and run length live in flops, handles in a memory.
  slot_st_e               status_q [MAX_SLOTS];
  logic [CNT_W-1:0]       len_q    [MAX_SLOTS];
  logic [HANDLE_BITS-1:0] handle_mem [MAX_SLOTS];

  // Requests from the sequencer to the slot table.
  logic             clr_all;
  logic             pend_wr;
  logic             mark_en;
  slot_st_e         mark_st;
  logic [SUM_W-1:0] mark_lo, mark_hi;

  logic             in_accept;
  logic             out_free;
  logic [CNT_W-1:0] cnt;
  logic [SLOT_W-1:0] rd_addr;
  slot_st_e         rd_st;
  logic [CNT_W-1:0] rd_len;
  logic [SUM_W-1:0] sub_end;
  logic [SUM_W-1:0] nxt;
  logic             walk_ok;
  logic             cfg_wr;

  // ---------------------------------------------------------------------------------------
  // Configuration register.
  // ---------------------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && !paddr[APB_AW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_count_q <= TASK_COUNT_RESET;
    end else if (cfg_wr) begin
      task_count_q <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == REG_TASK_COUNT_ADDR) begin
      prdata = APB_DW'(task_count_q);
    end
  end

  // Counts above the table size behave as the full table.
  assign cnt = (task_count_q > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : task_count_q;

  // ---------------------------------------------------------------------------------------
  // Handshakes and shared read port of the slot table.
  // ---------------------------------------------------------------------------------------
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // While decoding, the slot just before the range is checked; afterwards the walker index.
  assign rd_addr = (state_q == S_DECODE) ? (in_q.first_slot - SLOT_W'(1)) : idx_q[SLOT_W-1:0];
  assign rd_st   = status_q[rd_addr];
  assign rd_len  = len_q[rd_addr];

  assign sub_end = SUM_W'(in_q.first_slot) + SUM_W'(in_q.slot_run);
  assign nxt     = SUM_W'(idx_q) + SUM_W'(rd_len);

  // The walk continues into the next run only if it is a sound pending run inside the count
  // and the result cap is not yet reached.
  assign walk_ok = (rem_q != REM_W'(RESULT_CAP - 1)) && (idx_q < cnt) && (rd_st == ST_PEND)
                   && (rd_len != '0) && (nxt <= SUM_W'(cnt));

  // ---------------------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    disp_d      = disp_q;
    rel_d       = rel_q;
    idx_d       = idx_q;
    end_d       = end_q;
    fin_d       = fin_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_load    = 1'b0;
    out_d       = '0;
    out_d.last  = 1'b1;
    out_d.finished_slots = rel_q;
    clr_all     = 1'b0;
    pend_wr     = 1'b0;
    mark_en     = 1'b0;
    mark_st     = ST_DONE;
    mark_lo     = '0;
    mark_hi     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        if (out_free) begin
          state_d = S_IDLE;
          if (in_q.mode == MODE_RESTART) begin
            clr_all  = 1'b1;
            disp_d   = '0;
            rel_d    = '0;
            out_load = 1'b1;
            out_d.finished_slots = '0;
          end else if (in_q.mode == MODE_REQUEST) begin
            out_load = 1'b1;
            if (disp_q < cnt) begin
              out_d.granted      = 1'b1;
              out_d.granted_slot = disp_q[SLOT_W-1:0];
              mark_en = 1'b1;
              mark_st = ST_WAIT;
              mark_lo = SUM_W'(disp_q);
              mark_hi = SUM_W'(disp_q) + SUM_W'(1);
              disp_d  = disp_q + CNT_W'(1);
            end
          end else if (in_q.mode == MODE_SUBMIT) begin
            if ((in_q.slot_run == '0) || (sub_end > SUM_W'(cnt))) begin
              // Range is empty or runs past the task count: ignored.
              out_load = 1'b1;
            end else if ((in_q.first_slot != '0) && (rd_st != ST_DONE)) begin
              // Predecessor not released yet: hold the range as pending.
              out_load = 1'b1;
              pend_wr  = 1'b1;
              mark_en  = 1'b1;
              mark_st  = ST_PEND;
              mark_lo  = SUM_W'(in_q.first_slot);
              mark_hi  = sub_end;
            end else begin
              // Releasable: find how far the pending runs reach before emitting anything.
              state_d = S_SCAN;
              idx_d   = sub_end[CNT_W-1:0];
              end_d   = sub_end[CNT_W-1:0];
              fin_d   = sub_end[CNT_W-1:0];
              rem_d   = '0;
            end
          end else begin
            out_load = 1'b1;
          end
          out_valid_d = out_load ? 1'b1 : out_valid_d;
          if (out_load) begin
            out_d.all_finished = (out_d.finished_slots >= cnt);
          end
        end
      end

      S_SCAN: begin
        if (walk_ok) begin
          idx_d = nxt[CNT_W-1:0];
          fin_d = nxt[CNT_W-1:0];
          rem_d = rem_q + REM_W'(1);
        end else begin
          state_d = S_FIRST;
        end
      end

      S_FIRST: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          out_d.handle_valid    = 1'b1;
          out_d.released_handle = in_q.work_handle;
          out_d.last            = (rem_q == '0);
          out_d.finished_slots  = fin_q;
          out_d.all_finished    = (fin_q >= cnt);
          rel_d   = fin_q;
          mark_en = 1'b1;
          mark_lo = SUM_W'(in_q.first_slot);
          mark_hi = SUM_W'(end_q);
          idx_d   = end_q;
          state_d = (rem_q == '0) ? S_IDLE : S_READ;
        end
      end

      S_READ: begin
        // The handle memory read at idx_q lands in hrd_q at this edge.
        state_d = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          out_d.handle_valid    = 1'b1;
          out_d.released_handle = hrd_q;
          out_d.last            = (rem_q == REM_W'(1));
          out_d.finished_slots  = fin_q;
          out_d.all_finished    = (fin_q >= cnt);
          mark_en = 1'b1;
          mark_lo = SUM_W'(idx_q);
          mark_hi = nxt;
          idx_d   = nxt[CNT_W-1:0];
          rem_d   = rem_q - REM_W'(1);
          state_d = (rem_q == REM_W'(1)) ? S_IDLE : S_READ;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      disp_q      <= '0;
      rel_q       <= '0;
      idx_q       <= '0;
      end_q       <= '0;
      fin_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      disp_q      <= disp_d;
      rel_q       <= rel_d;
      idx_q       <= idx_d;
      end_q       <= end_d;
      fin_q       <= fin_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Slot table.
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        status_q[i] <= ST_WAIT;
        len_q[i]    <= '0;
      end
    end else if (clr_all) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        status_q[i] <= ST_WAIT;
        len_q[i]    <= '0;
      end
    end else begin
      // Range marking compares every slot index against the bounds at once.
      for (int i = 0; i < MAX_SLOTS; i++) begin
        if (mark_en && (SUM_W'(i) >= mark_lo) && (SUM_W'(i) < mark_hi)) begin
          status_q[i] <= mark_st;
        end
      end
      if (pend_wr) begin
        len_q[in_q.first_slot] <= in_q.slot_run;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_wr) begin
      handle_mem[in_q.first_slot] <= in_q.work_handle;
    end
    hrd_q <= handle_mem[idx_q[SLOT_W-1:0]];
  end

endmodule

`default_nettype wire

// ----- bench/tb_in_order_task_retire_buffer.sv -----
// Self-checking testbench for the in-order task retire buffer: directed cases, then random
// task frames under three idling regimes, all checked against an in-bench slot-table predictor.
// Depends on itrb_pkg and in_order_task_retire_buffer from hw/rtl.
`timescale 1ns / 100ps

module tb_in_order_task_retire_buffer;
  import itrb_pkg::*;

  // The run is cut off here; a correct run needs a small fraction of it.
  localparam int CYCLE_LIMIT   = 1_000_000;
  // Extra idle time after every owed result is taken, so no work is left in flight.
  localparam int SETTLE_CYCLES = 8;
  // The fourth mode code has no name in the package; the block must treat it as a no-op.
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic                   clk_i    = 1'b0;
  logic                   rst_ni   = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_item_t               in_data  = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_data;
  logic                   psel     = 1'b0;
  logic                   penable  = 1'b0;
  logic                   pwrite   = 1'b0;
  logic [APB_AW-1:0]      paddr    = '0;
  logic [APB_DW-1:0]      pwdata   = '0;
  logic [APB_DW-1:0]      prdata;
  logic                   pready;

  in_order_task_retire_buffer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #10 clk_i = ~clk_i;

  // Predictor state: a private copy of the slot table, the two counters and the register.
  int                     task_count_cfg = int'(TASK_COUNT_RESET);
  slot_st_e               slot_state [MAX_SLOTS];
  logic [CNT_W-1:0]       slot_len   [MAX_SLOTS];
  logic [HANDLE_BITS-1:0] slot_token [MAX_SLOTS];
  int                     dispatched_cnt = 0;
  int                     released_cnt   = 0;

  // Result items still owed by the block, oldest first.
  out_item_t              due_results [$];

  int mismatch_count = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int config_writes  = 0;
  int frames_run     = 0;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;

  // ---------------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------------

  // Register values above the table size behave as the table size.
  function automatic int active_slots();
    return (task_count_cfg > MAX_SLOTS) ? MAX_SLOTS : task_count_cfg;
  endfunction

  function automatic void mark_slots(int from, int upto, slot_st_e st);
    for (int i = from; i < upto && i < MAX_SLOTS; i++) slot_state[i] = st;
  endfunction

  // Every result carries the counter as it stands after the whole input, so the
  // predictor only queues results once the state update is complete.
  function automatic void queue_result(logic granted, int slot, logic hv,
                                       logic [HANDLE_BITS-1:0] token, logic last_flag);
    out_item_t r;
    r.granted         = granted;
    r.granted_slot    = SLOT_W'(slot);
    r.handle_valid    = hv;
    r.released_handle = token;
    r.last            = last_flag;
    r.finished_slots  = CNT_W'(released_cnt);
    r.all_finished    = (released_cnt >= active_slots());
    due_results = {due_results, r};
  endfunction

  function automatic void predict_item(in_item_t item);
    int lim, stop, idx, len, nend;
    logic [HANDLE_BITS-1:0] tokens [$];
    lim  = active_slots();
    stop = int'(item.first_slot) + int'(item.slot_run);
    case (item.mode)
      MODE_RESTART: begin
        mark_slots(0, MAX_SLOTS, ST_WAIT);
        foreach (slot_len[i]) slot_len[i] = '0;
        dispatched_cnt = 0;
        released_cnt   = 0;
        queue_result(1'b0, 0, 1'b0, '0, 1'b1);
      end
      MODE_REQUEST: begin
        if (dispatched_cnt < lim) begin
          slot_state[dispatched_cnt] = ST_WAIT;
          dispatched_cnt++;
          queue_result(1'b1, dispatched_cnt - 1, 1'b0, '0, 1'b1);
        end else begin
          queue_result(1'b0, 0, 1'b0, '0, 1'b1);
        end
      end
      MODE_SUBMIT: begin
        if (item.slot_run == 0 || stop > lim) begin
          // Empty range or one running past the task count: ignored.
          queue_result(1'b0, 0, 1'b0, '0, 1'b1);
        end else if (item.first_slot != 0 && slot_state[item.first_slot - 1] != ST_DONE) begin
          // The slot before the range is not out yet, so the range waits.
          slot_token[item.first_slot] = item.work_handle;
          slot_len[item.first_slot]   = item.slot_run;
          mark_slots(item.first_slot, stop, ST_PEND);
          queue_result(1'b0, 0, 1'b0, '0, 1'b1);
        end else begin
          mark_slots(item.first_slot, stop, ST_DONE);
          released_cnt = stop;
          tokens = {tokens, item.work_handle};
          idx = stop;
          // Follow the waiting runs; a zero length or a run past the count ends the walk.
          while (tokens.size() < RESULT_CAP && idx < lim && slot_state[idx] == ST_PEND) begin
            len  = int'(slot_len[idx]);
            nend = idx + len;
            if (len == 0 || nend > lim) break;
            tokens = {tokens, slot_token[idx]};
            mark_slots(idx, nend, ST_DONE);
            released_cnt = nend;
            idx = nend;
          end
          foreach (tokens[k]) queue_result(1'b0, 0, 1'b1, tokens[k], k == tokens.size() - 1);
        end
      end
      default: begin
        queue_result(1'b0, 0, 1'b0, '0, 1'b1);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------------------
  // Result checking, receiver stalls and the watchdog
  // ---------------------------------------------------------------------------------------

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Outputs are sampled at the edge that takes the result, before any register updates.
  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      results_seen++;
      if (due_results.size() == 0) begin
        $error("result item %h arrived with no expectation waiting", out_data);
        mismatch_count++;
      end else begin
        want = due_results.pop_front();
        compare_field("granted", want.granted, out_data.granted);
        compare_field("granted_slot", want.granted_slot, out_data.granted_slot);
        compare_field("handle_valid", want.handle_valid, out_data.handle_valid);
        compare_field("released_handle", want.released_handle, out_data.released_handle);
        compare_field("last", want.last, out_data.last);
        compare_field("finished_slots", want.finished_slots, out_data.finished_slots);
        compare_field("all_finished", want.all_finished, out_data.all_finished);
      end
    end
  end

  // The receiver drops ready at random; ready may change whether or not a result waits.
  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------------------

  // Presents one item and returns at the edge that accepts it. Valid is left high so that
  // a following item can go out back to back; anything that pauses lowers it first.
  task automatic send_item(logic [1:0] mode, int first, int run,
                           logic [HANDLE_BITS-1:0] token);
    in_item_t item;
    item.mode        = mode;
    item.first_slot  = SLOT_W'(first);
    item.slot_run    = CNT_W'(run);
    item.work_handle = token;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (in_ready !== 1'b1);
    predict_item(item);
    items_sent++;
  endtask

  // Holds off the sender until every owed result has been taken, then lets the block settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write: a setup phase, then an access phase that completes when pready is high.
  task automatic write_task_count(int value);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_TASK_COUNT_ADDR;
    pwdata  <= APB_DW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    task_count_cfg = value & 6'h3F;
    config_writes++;
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Grants come out in slot order until the task count is used up; a one-slot frame
  // shows the refusal and the all-finished flag at a count of one.
  task automatic test_grants_and_restart();
    send_item(MODE_RESTART, 31, 32, 16'hFFFF);
    send_item(MODE_REQUEST, 0, 1, 16'h0000);
    send_item(MODE_REQUEST, 31, 0, 16'hFFFF);
    write_task_count(1);
    send_item(MODE_RESTART, 0, 0, 16'h0000);
    send_item(MODE_REQUEST, 0, 0, 16'h0000);
    send_item(MODE_REQUEST, 0, 0, 16'h0000);
    send_item(MODE_SUBMIT, 0, 1, 16'hFFFF);
  endtask

  // Pending, ignored, unused-mode, chained release, a resubmit that pulls the count back,
  // and one range that covers the whole table.
  task automatic test_submit_cases();
    write_task_count(MAX_SLOTS);
    send_item(MODE_RESTART, 0, 0, 16'h0000);
    send_item(MODE_SUBMIT, 31, 1, 16'h0000);
    send_item(MODE_SUBMIT, 0, 0, HANDLE_BITS'($urandom));
    send_item(MODE_SUBMIT, 31, 2, HANDLE_BITS'($urandom));
    send_item(MODE_UNUSED, 5, 3, 16'hFFFF);
    send_item(MODE_SUBMIT, 1, 2, 16'hA5A5);
    send_item(MODE_SUBMIT, 0, 1, 16'h0000);
    send_item(MODE_SUBMIT, 0, 1, 16'h1234);
    send_item(MODE_RESTART, 0, 0, 16'h0000);
    send_item(MODE_SUBMIT, 0, 32, 16'hFFFF);
  endtask

  // Overlapping submits leave a pending slot with no length, which stops the walk. A run
  // stored under a larger count stops it too once the count has been lowered.
  task automatic test_broken_marks();
    send_item(MODE_RESTART, 0, 0, 16'h0000);
    send_item(MODE_SUBMIT, 2, 2, HANDLE_BITS'($urandom));
    send_item(MODE_SUBMIT, 3, 2, HANDLE_BITS'($urandom));
    send_item(MODE_SUBMIT, 0, 2, HANDLE_BITS'($urandom));
    send_item(MODE_SUBMIT, 20, 10, HANDLE_BITS'($urandom));
    write_task_count(25);
    send_item(MODE_SUBMIT, 0, 20, HANDLE_BITS'($urandom));
    send_item(MODE_SUBMIT, 20, 6, HANDLE_BITS'($urandom));
  endtask

  // A zero count never grants and always reads as finished; an oversized count acts as
  // the full table, while the register reads back as written.
  task automatic test_count_extremes();
    write_task_count(0);
    send_item(MODE_REQUEST, 0, 0, 16'h0000);
    write_task_count(63);
    @(posedge clk_i);
    compare_field("task_count", 32'd63, prdata);
    send_item(MODE_RESTART, 0, 0, 16'h0000);
    send_item(MODE_REQUEST, 0, 0, 16'h0000);
    write_task_count(MAX_SLOTS);
  endtask

  // One frame as software would run it: an optional new count, a restart, the slot
  // requests, then a random partition of the slots submitted in random order. Now and
  // then a stray item lands in between to disturb the table.
  task automatic random_frame();
    int lim, pos, len, span, nreq, i, j, tmp;
    int run_first [$];
    int run_len [$];
    if ($urandom_range(1) == 1) begin
      j = $urandom_range(9);
      if (j < 6) write_task_count($urandom_range(8, 1));
      else if (j < 9) write_task_count($urandom_range(31, 9));
      else write_task_count(MAX_SLOTS);
    end
    lim = active_slots();
    send_item(MODE_RESTART, $urandom_range(31), $urandom_range(32), HANDLE_BITS'($urandom));
    nreq = ($urandom_range(3) == 0) ? $urandom_range(lim) : lim + $urandom_range(1);
    repeat (nreq) begin
      send_item(MODE_REQUEST, $urandom_range(31), $urandom_range(32), HANDLE_BITS'($urandom));
    end
    // Mostly short runs, sometimes one that may run up to all that is left.
    pos = 0;
    while (pos < lim) begin
      span = ($urandom_range(7) == 0 || lim - pos < 4) ? lim - pos : 4;
      len  = $urandom_range(span, 1);
      run_first = {run_first, pos};
      run_len   = {run_len, len};
      pos += len;
    end
    for (i = run_first.size() - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = run_first[i]; run_first[i] = run_first[j]; run_first[j] = tmp;
      tmp = run_len[i];   run_len[i]   = run_len[j];   run_len[j]   = tmp;
    end
    foreach (run_first[k]) begin
      if ($urandom_range(6) == 0) begin
        j = $urandom_range(9);
        if (j == 0) send_item(MODE_RESTART, 0, 0, HANDLE_BITS'($urandom));
        else if (j == 1) send_item(MODE_UNUSED, $urandom_range(31), $urandom_range(32),
                                   HANDLE_BITS'($urandom));
        else if (j == 2) send_item(MODE_REQUEST, 0, 0, HANDLE_BITS'($urandom));
        else send_item(MODE_SUBMIT, $urandom_range(31), $urandom_range(32),
                       HANDLE_BITS'($urandom));
      end
      send_item(MODE_SUBMIT, run_first[k], run_len[k], HANDLE_BITS'($urandom));
    end
  endtask

  task automatic run_random_phase(int send_pct, int recv_pct, int goal);
    int start;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start = items_sent;
    while (items_sent - start < goal) begin
      random_frame();
      frames_run++;
    end
  endtask

  // Every slot waits as a single-slot run until slot zero arrives; that one submit then
  // releases the whole table, the most results a single item can cause.
  task automatic test_longest_release();
    int s;
    write_task_count(MAX_SLOTS);
    send_item(MODE_RESTART, 0, 0, 16'h0000);
    for (s = MAX_SLOTS - 1; s > 0; s--) send_item(MODE_SUBMIT, s, 1, HANDLE_BITS'($urandom));
    send_item(MODE_SUBMIT, 0, 1, HANDLE_BITS'($urandom));
  endtask

  // ---------------------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------------------

  initial begin
    foreach (slot_state[i]) begin
      slot_state[i] = ST_WAIT;
      slot_len[i]   = '0;
      slot_token[i] = '0;
    end
    // Directed cases and the first random phase run with a slow receiver.
    send_idle_pct = 27;
    recv_idle_pct = 71;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_grants_and_restart();
    test_submit_cases();
    test_broken_marks();
    test_count_extremes();

    run_random_phase(27, 71, 45);
    run_random_phase(71, 27, 45);
    run_random_phase(0, 0, 30);
    test_longest_release();

    wait_idle();
    repeat (4 * SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d items (%0d random frames), checked %0d results, %0d count writes.",
             items_sent, frames_run, results_seen, config_writes);
    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
